// ===== src/lcdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcdt_pkg;

   localparam logic [7:0] VISIBLE_LINES = 8'd144;
   localparam logic [7:0] TOTAL_LINES   = 8'd154;

   localparam logic [15:0] OAM_CYCLES    = 16'd80;
   localparam logic [15:0] XFER_CYCLES   = 16'd172;
   localparam logic [15:0] HBLANK_CYCLES = 16'd204;
   localparam logic [15:0] LINE_CYCLES   = 16'd456;

   localparam int IRQ_EN_HBLANK = 0;
   localparam int IRQ_EN_VBLANK = 1;
   localparam int IRQ_EN_OAM    = 2;
   localparam int IRQ_EN_COINC  = 3;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_LCD_ENABLE       = 2'd0,
      CSR_LINE_COMPARE     = 2'd1,
      CSR_STAT_IRQ_ENABLES = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       lcd_enable;
      logic [7:0] line_compare;
      logic [3:0] stat_irq_enables;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  line;
      logic [15:0] count;
      mode_type    reported;
      logic        coincidence;
   } state_type;

   // Packed with line_number in the lowest bits.
   typedef struct packed {
      logic       vblank_irq;
      logic       stat_irq;
      logic       coincidence;
      mode_type   reported_mode;
      mode_type   current_mode;
      logic [7:0] line_number;
   } rsp_type;

   localparam int RSP_BITS   = $bits(rsp_type);
   localparam int RSP_TBYTES = (RSP_BITS + 7) / 8;

endpackage

`default_nettype wire

// ===== src/lcdt_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcdt_step (
   input  var lcdt_pkg::cfg_type   cfg,
   input  var lcdt_pkg::state_type state,
   input  wire logic [7:0]         elapsed_cycles,
   output lcdt_pkg::state_type     state_in,
   output lcdt_pkg::rsp_type       rsp
);
   import lcdt_pkg::*;

   logic [16:0] sum;
   logic [15:0] count_sat;
   logic [7:0]  line_inc;
   logic        inc_match;
   logic        zero_match;
   logic        stat_hit;
   logic        vbl_hit;

   assign sum        = {1'b0, state.count} + {9'd0, elapsed_cycles};
   assign count_sat  = sum[16] ? 16'hFFFF : sum[15:0];
   assign line_inc   = state.line + 8'd1;
   assign inc_match  = (line_inc == cfg.line_compare);
   assign zero_match = (cfg.line_compare == 8'd0);

   always_comb begin
      state_in = state;
      stat_hit = 1'b0;
      vbl_hit  = 1'b0;
      if (cfg.lcd_enable) begin
         state_in.count    = count_sat;
         state_in.reported = state.mode;
         unique case (state.mode)
            MODE_OAM: begin
               if (count_sat > OAM_CYCLES) begin
                  stat_hit       = cfg.stat_irq_enables[IRQ_EN_OAM];
                  state_in.mode  = MODE_XFER;
                  state_in.count = count_sat - OAM_CYCLES;
               end
            end
            MODE_XFER: begin
               if (count_sat > XFER_CYCLES) begin
                  state_in.mode  = MODE_HBLANK;
                  state_in.count = count_sat - XFER_CYCLES;
               end
            end
            MODE_HBLANK: begin
               if (count_sat > HBLANK_CYCLES) begin
                  stat_hit = cfg.stat_irq_enables[IRQ_EN_HBLANK]
                           | (inc_match & cfg.stat_irq_enables[IRQ_EN_COINC]);
                  state_in.line        = line_inc;
                  state_in.coincidence = inc_match;
                  state_in.count       = count_sat - HBLANK_CYCLES;
                  if (line_inc == VISIBLE_LINES) begin
                     state_in.mode = MODE_VBLANK;
                     vbl_hit       = 1'b1;
                  end else begin
                     state_in.mode = MODE_OAM;
                  end
               end
            end
            MODE_VBLANK: begin
               if (count_sat > LINE_CYCLES) begin
                  stat_hit = cfg.stat_irq_enables[IRQ_EN_VBLANK]
                           | (inc_match & cfg.stat_irq_enables[IRQ_EN_COINC]);
                  state_in.line        = line_inc;
                  state_in.coincidence = inc_match;
                  state_in.count       = count_sat - LINE_CYCLES;
                  if (line_inc == TOTAL_LINES) begin
                     // The wrap to line 0 is compared a second time.
                     state_in.mode        = MODE_OAM;
                     state_in.line        = 8'd0;
                     state_in.coincidence = zero_match;
                     stat_hit = stat_hit
                              | (zero_match & cfg.stat_irq_enables[IRQ_EN_COINC]);
                  end
               end
            end
            default: begin
               state_in = state;
            end
         endcase
      end
   end

   assign rsp.line_number   = state_in.line;
   assign rsp.current_mode  = state_in.mode;
   assign rsp.reported_mode = state_in.reported;
   assign rsp.coincidence   = state_in.coincidence;
   assign rsp.stat_irq      = stat_hit;
   assign rsp.vblank_irq    = vbl_hit;

endmodule

`default_nettype wire

// ===== src/lcdt_rsp_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcdt_rsp_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  var lcdt_pkg::rsp_type  push_data,
   output logic                   full,
   output logic                   out_valid,
   output lcdt_pkg::rsp_type      out_data,
   input  wire logic              out_ready
);
   import lcdt_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   rsp_type    slot_ff [2];
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/lcd_mode_line_timing.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Display mode and scanline timer. Each req transaction carries elapsed_cycles, the CPU time
// passed since the previous one, and produces exactly one rsp transaction with the line number,
// the mode after the step, the status mode bits, the coincidence flag and the two
// interrupt pulses. One item is taken every clock cycle unless the queue is full; the timing
// state is updated in the cycle of acceptance and the result is written into a two-entry
// output queue that drives rsp, so the input keeps flowing while one result waits. The input
// stalls only when both queue entries are occupied. The csr port writes lcd_enable,
// line_compare and stat_irq_enables and should be used only when no result is pending.

module lcd_mode_line_timing (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] elapsed_cycles
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] line_number, [9:8] current_mode, [11:10] reported_mode, [12] coincidence,
   // [13] stat_irq, [14] vblank_irq, [15] zero
   output logic [lcdt_pkg::RSP_TBYTES*8-1:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);
   import lcdt_pkg::*;

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;
   rsp_type   buf_rsp;
   logic      buf_full;
   logic      accept;

   assign req_tready = !buf_full;
   assign accept     = req_tvalid && req_tready;

   lcdt_step u_step (
      .cfg            (cfg_ff),
      .state          (state_ff),
      .elapsed_cycles (req_tdata),
      .state_in       (state_in),
      .rsp            (step_rsp)
   );

   lcdt_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_rsp),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_data  (buf_rsp),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {{(RSP_TBYTES*8-RSP_BITS){1'b0}}, buf_rsp};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LCD_ENABLE:       cfg_ff.lcd_enable       <= csr_wdata[0];
            CSR_LINE_COMPARE:     cfg_ff.line_compare     <= csr_wdata;
            CSR_STAT_IRQ_ENABLES: cfg_ff.stat_irq_enables <= csr_wdata[3:0];
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_OAM;
         state_ff.line        <= 8'd0;
         state_ff.count       <= 16'd0;
         state_ff.reported    <= MODE_HBLANK;
         state_ff.coincidence <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/lcdt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcdt_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tready,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [lcdt_pkg::RSP_TBYTES*8-1:0] rsp_tdata
);
   import lcdt_pkg::*;

   rsp_type rsp;
   assign rsp = rsp_tdata[RSP_BITS-1:0];

   // A stalled result stays on the bus unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // The input only stalls when results are pending.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with no pending rsp");

   // The vertical blank interrupt fires only on entry into vblank at the first hidden line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.vblank_irq |->
         rsp.current_mode == MODE_VBLANK && rsp.line_number == VISIBLE_LINES
         && rsp.reported_mode == MODE_HBLANK)
      else $error("vblank interrupt outside vblank entry");

   // Vblank only covers the hidden lines.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.current_mode == MODE_VBLANK |->
         rsp.line_number >= VISIBLE_LINES && rsp.line_number < TOTAL_LINES)
      else $error("vblank on a visible line");

endmodule

bind lcd_mode_line_timing lcdt_checker u_lcdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import lcdt_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RSP_WIDTH   = RSP_TBYTES * 8;

   typedef enum int {DRAW_UNIFORM, DRAW_EXTREME, DRAW_HEAVY} draw_style_type;
   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_LONG_STALL, READY_MOSTLY} ready_style_type;

   class lcd_scoreboard_type;
      bit          lcd_on;
      bit [7:0]    line_cmp;
      bit [3:0]    irq_en;
      mode_type    mode;
      bit [7:0]    line;
      int unsigned dot_count;
      mode_type    status_mode;
      bit          coinc;
      rsp_type     predicted_q[$];
      int          errors;
      int          results;
      int          stat_pulses;
      int          vblank_pulses;
      int          coinc_hits;
      int          saturated;
      int          frames;

      function new();
         lcd_on = 1'b0;
         line_cmp = '0;
         irq_en = '0;
         mode = MODE_OAM;
         line = '0;
         dot_count = 0;
         status_mode = MODE_HBLANK;
         coinc = 1'b0;
         errors = 0;
         results = 0;
         stat_pulses = 0;
         vblank_pulses = 0;
         coinc_hits = 0;
         saturated = 0;
         frames = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [7:0] value);
         case (idx)
            CSR_LCD_ENABLE: lcd_on = value[0];
            CSR_LINE_COMPARE: line_cmp = value;
            CSR_STAT_IRQ_ENABLES: irq_en = value[3:0];
            default: ;
         endcase
      endfunction

      function bit line_match();
         coinc = (line == line_cmp);
         if (coinc) coinc_hits++;
         return coinc && irq_en[IRQ_EN_COINC];
      endfunction

      function void note_request(bit [7:0] elapsed);
         rsp_type r;
         bit      stat_hit;
         bit      vbl_hit;
         stat_hit = 1'b0;
         vbl_hit = 1'b0;
         if (lcd_on) begin
            dot_count += 32'(elapsed);
            if (dot_count > 32'hFFFF) begin
               dot_count = 32'hFFFF;
               saturated++;
            end
            status_mode = mode;
            case (mode)
               MODE_OAM: begin
                  if (dot_count > 32'(OAM_CYCLES)) begin
                     stat_hit = irq_en[IRQ_EN_OAM];
                     mode = MODE_XFER;
                     dot_count -= 32'(OAM_CYCLES);
                  end
               end
               MODE_XFER: begin
                  if (dot_count > 32'(XFER_CYCLES)) begin
                     mode = MODE_HBLANK;
                     dot_count -= 32'(XFER_CYCLES);
                  end
               end
               MODE_HBLANK: begin
                  if (dot_count > 32'(HBLANK_CYCLES)) begin
                     stat_hit = irq_en[IRQ_EN_HBLANK];
                     line = line + 8'd1;
                     if (line_match()) stat_hit = 1'b1;
                     if (line == VISIBLE_LINES) begin
                        mode = MODE_VBLANK;
                        vbl_hit = 1'b1;
                     end else begin
                        mode = MODE_OAM;
                     end
                     dot_count -= 32'(HBLANK_CYCLES);
                  end
               end
               default: begin
                  if (dot_count > 32'(LINE_CYCLES)) begin
                     stat_hit = irq_en[IRQ_EN_VBLANK];
                     line = line + 8'd1;
                     if (line_match()) stat_hit = 1'b1;
                     if (line == TOTAL_LINES) begin
                        mode = MODE_OAM;
                        line = '0;
                        frames++;
                        if (line_match()) stat_hit = 1'b1;
                     end
                     dot_count -= 32'(LINE_CYCLES);
                  end
               end
            endcase
         end
         r.line_number = line;
         r.current_mode = mode;
         r.reported_mode = status_mode;
         r.coincidence = coinc;
         r.stat_irq = stat_hit;
         r.vblank_irq = vbl_hit;
         predicted_q = {predicted_q, r};
      endfunction

      function void field_check(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(logic [RSP_WIDTH-1:0] data);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(data[RSP_BITS-1:0]);
         if (predicted_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, actual 0x%0h", $time, data);
            return;
         end
         want = predicted_q.pop_front();
         results++;
         if (want.stat_irq) stat_pulses++;
         if (want.vblank_irq) vblank_pulses++;
         field_check("line_number", 16'(want.line_number), 16'(got.line_number));
         field_check("current_mode", 16'(want.current_mode), 16'(got.current_mode));
         field_check("reported_mode", 16'(want.reported_mode), 16'(got.reported_mode));
         field_check("coincidence", 16'(want.coincidence), 16'(got.coincidence));
         field_check("stat_irq", 16'(want.stat_irq), 16'(got.stat_irq));
         field_check("vblank_irq", 16'(want.vblank_irq), 16'(got.vblank_irq));
         field_check("padding", '0, 16'(data >> RSP_BITS));
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_WIDTH-1:0] rsp_tdata;
   logic                 csr_we;
   logic [1:0]           csr_addr;
   logic [7:0]           csr_wdata;
   int                   cycles = 0;

   lcd_scoreboard_type sb = new();

   lcd_mode_line_timing dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(HALF_PERIOD) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL lcd_mode_line_timing");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   initial begin
      ready_style_type style;
      int              span;
      rsp_tready = 1'b0;
      forever begin
         style = ready_style_type'($urandom_range(0, 3));
         span = $urandom_range(16, 160);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
               READY_LONG_STALL: rsp_tready <= (k % 16) >= 12;
               default: rsp_tready <= (k % 4) != 3;
            endcase
         end
      end
   end

   function automatic bit [7:0] pick_elapsed(draw_style_type style);
      case (style)
         DRAW_EXTREME: begin
            case ($urandom_range(0, 5))
               0: return 8'd0;
               1: return 8'd1;
               2: return 8'd255;
               3: return 8'd254;
               4: return 8'($urandom_range(0, 15));
               default: return 8'($urandom_range(0, 255));
            endcase
         end
         DRAW_HEAVY: return ($urandom_range(0, 31) == 0) ? 8'($urandom_range(0, 255)) : 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_item(bit [7:0] value);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(value);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic run_items(int n, draw_style_type style);
      int left;
      int burst;
      int gap;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 48);
         if (burst > left) burst = left;
         repeat (burst) send_item(pick_elapsed(style));
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            stop_sending();
            repeat (gap - 1) @(negedge clock);
         end
      end
      stop_sending();
   endtask

   task automatic settle();
      stop_sending();
      while (sb.predicted_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [7:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic configure(bit on, bit [7:0] cmp, bit [3:0] en);
      settle();
      write_csr(CSR_LCD_ENABLE, {7'd0, on});
      write_csr(CSR_LINE_COMPARE, cmp);
      write_csr(CSR_STAT_IRQ_ENABLES, {4'd0, en});
   endtask

   initial begin
      bit [7:0] directed[] = '{8'd80, 8'd1, 8'd0, 8'd172, 8'd203, 8'd1, 8'd255, 8'd255,
                               8'd255, 8'd128, 8'd64, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                               8'd2, 8'd254};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The display is still off after reset, so these steps must change nothing.
      send_item(8'd255);
      send_item(8'd0);
      configure(1'b1, 8'd0, 4'hF);
      foreach (directed[i]) send_item(directed[i]);

      configure(1'b1, 8'd144, 4'hF);
      run_items(250, DRAW_UNIFORM);
      configure(1'b1, 8'd153, 4'b0101);
      run_items(200, DRAW_UNIFORM);
      configure(1'b0, 8'd7, 4'hF);
      run_items(40, DRAW_UNIFORM);
      configure(1'b1, 8'd0, 4'b1010);
      run_items(150, DRAW_EXTREME);
      configure(1'b1, 8'd255, 4'h0);
      run_items(120, DRAW_UNIFORM);
      configure(1'b1, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      run_items(120, DRAW_UNIFORM);
      configure(1'b1, 8'($urandom_range(0, 153)), 4'hF);
      run_items(800, DRAW_HEAVY);
      settle();
      repeat (10) @(posedge clock);

      $display("Checked %0d results with %0d status and %0d vblank interrupts expected.",
               sb.results, sb.stat_pulses, sb.vblank_pulses);
      $display("Saw %0d line matches, %0d full frames and %0d counter saturations.",
               sb.coinc_hits, sb.frames, sb.saturated);
      if (sb.errors == 0 && sb.predicted_q.size() == 0) begin
         $display("PASS lcd_mode_line_timing");
      end else begin
         $display("FAIL lcd_mode_line_timing");
      end
      $finish;
   end

endmodule

// ===== lcd_mode_line_timing.f =====
src/lcdt_pkg.sv
src/lcdt_step.sv
src/lcdt_rsp_buf.sv
src/lcd_mode_line_timing.sv
src/lcdt_checker.sv
dv/tb_top.sv
